>>> hw/rtl/oahs_pkg.sv
`timescale 1ns / 1ps
package oahs_pkg;
	localparam int TABLE_SIZE_DEF = 1024;
	localparam int KEY_CHARS_DEF = 8;
	localparam logic [31:0] HASH_MULT = 32'd2047;

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_DEL = 2'd1,
		ACT_QRY = 2'd2,
		ACT_NOP = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0] action;
		logic [63:0] key_bytes;
		logic [3:0] key_length;
	} in_item_t;

	typedef struct packed {
		logic ok;
		logic full_res;
	} out_item_t;

	// classified job handed from the front to the back
	typedef struct packed {
		logic [1:0] action;
		logic [63:0] key;
		logic [3:0] len;
		logic [31:0] hash;
	} job_t;

	typedef enum logic [2:0] {
		FR_IDLE,
		FR_HASH,
		FR_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ,
		BK_CHECK,
		BK_WRITE,
		BK_DONE
	} back_state_t;
endpackage

>>> hw/rtl/oahs_front.sv
`timescale 1ns / 1ps
module oahs_front import oahs_pkg::*; #(
	parameter int KEY_CHARS = KEY_CHARS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic job_valid,
	input logic job_ready,
	output job_t job
);
	front_state_t state_q, state_d;
	logic [1:0] act_q;
	logic [63:0] key_q;
	logic [3:0] len_q;
	logic [31:0] hash_q;
	logic [3:0] cnt_q;
	logic [3:0] eff_len;
	logic [63:0] masked;

	always_comb begin
		eff_len = (in_data.key_length > 4'(KEY_CHARS)) ? 4'(KEY_CHARS) : in_data.key_length;
		for (int b = 0; b < 8; b++)
			masked[8*b +: 8] = (4'(b) < eff_len) ? in_data.key_bytes[8*b +: 8] : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// one horner step per cycle
	always_ff @(posedge clk) begin
		if (state_q == FR_IDLE && in_valid) begin
			act_q <= in_data.action;
			key_q <= masked;
			len_q <= eff_len;
			hash_q <= '0;
			cnt_q <= '0;
		end else if (state_q == FR_HASH) begin
			hash_q <= hash_q * HASH_MULT + {24'd0, key_q[8*cnt_q[2:0] +: 8]};
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		job_valid = 1'b0;
		unique case (state_q)
			FR_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = FR_HASH;
			end
			FR_HASH: begin
				if (cnt_q + 4'd1 >= len_q || len_q == 4'd0) state_d = FR_PUSH;
				if (len_q == 4'd0) state_d = FR_PUSH;
			end
			FR_PUSH: begin
				job_valid = 1'b1;
				if (job_ready) state_d = FR_IDLE;
			end
			default: state_d = FR_IDLE;
		endcase
	end

	// zero length: the one hash step taken is overridden, so the hash is zero
	logic [31:0] hash_out;
	assign hash_out = (len_q == 4'd0) ? 32'd0 : hash_q;
	assign job = '{action: act_q, key: key_q, len: len_q, hash: hash_out};
endmodule

>>> hw/rtl/oahs_queue.sv
`timescale 1ns / 1ps
module oahs_queue import oahs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input job_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output job_t rd_data
);
	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= ~wp_q;
			if (rd_valid && rd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
		end
	end
endmodule

>>> hw/rtl/oahs_back.sv
`timescale 1ns / 1ps
module oahs_back import oahs_pkg::*; #(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_ready,
	input job_t job,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data
);
	localparam int AW = $clog2(TABLE_SIZE);
	localparam int CW = AW + 1;

	// entry: {used, tomb, len, key}
	logic [63:0] key_mem [TABLE_SIZE];
	logic [3:0] len_mem [TABLE_SIZE];
	logic [1:0] flag_mem [TABLE_SIZE];

	back_state_t state_q, state_d;
	job_t job_q;
	logic [AW-1:0] idx_q, tomb_idx_q, wr_idx;
	logic [CW-1:0] i_q;
	logic have_tomb_q;
	logic [63:0] rkey_q;
	logic [3:0] rlen_q;
	logic [1:0] rflag_q;
	out_item_t res_q;
	logic clr_done;
	logic we;
	logic [1:0] wflag;
	logic rd_used, rd_tomb, rd_match, walk_end;

	assign rd_used = rflag_q[1];
	assign rd_tomb = rflag_q[0];
	assign rd_match = rd_used && !rd_tomb && rlen_q == job_q.len && rkey_q == job_q.key;
	assign walk_end = !rd_used || (i_q == CW'(TABLE_SIZE - 1));
	assign clr_done = (idx_q == AW'(TABLE_SIZE - 1));

	always_ff @(posedge clk) begin
		if (we) begin
			flag_mem[wr_idx] <= wflag;
			if (state_q != BK_CLEAR && !(state_q == BK_CHECK)) begin
				key_mem[wr_idx] <= job_q.key;
				len_mem[wr_idx] <= job_q.len;
			end
		end
		rkey_q <= key_mem[idx_q];
		rlen_q <= len_mem[idx_q];
		rflag_q <= flag_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			idx_q <= '0;
			i_q <= '0;
			have_tomb_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				BK_CLEAR: idx_q <= idx_q + AW'(1);
				BK_IDLE: if (job_valid) begin
					idx_q <= job.hash[AW-1:0];
					i_q <= '0;
					have_tomb_q <= 1'b0;
				end
				BK_CHECK: if (!(rd_match || walk_end && !rd_used)) begin
					if (rd_tomb && !have_tomb_q && rd_used) begin
						have_tomb_q <= 1'b1;
					end
					idx_q <= idx_q + AW'(i_q) + AW'(1);
					i_q <= i_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && job_valid) job_q <= job;
		if (state_q == BK_CHECK && rd_used && rd_tomb && !have_tomb_q) tomb_idx_q <= idx_q;
	end

	always_comb begin
		state_d = state_q;
		job_ready = 1'b0;
		out_valid = 1'b0;
		we = 1'b0;
		wr_idx = idx_q;
		wflag = 2'b00;
		unique case (state_q)
			BK_CLEAR: begin
				we = 1'b1;
				if (clr_done) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) state_d = BK_READ;
			end
			BK_READ: state_d = BK_CHECK;
			BK_CHECK: begin
				if (job_q.action == ACT_NOP) begin
					state_d = BK_DONE;
				end else if (rd_match) begin
					if (job_q.action == ACT_DEL) begin
						we = 1'b1;
						wflag = 2'b11;
					end
					state_d = BK_DONE;
				end else if (walk_end) begin
					if (job_q.action == ACT_ADD && (have_tomb_q || !rd_used ||
						rd_tomb)) state_d = BK_WRITE;
					else state_d = BK_DONE;
				end else begin
					state_d = BK_READ;
				end
			end
			BK_WRITE: begin
				we = 1'b1;
				wflag = 2'b10;
				wr_idx = have_tomb_q ? tomb_idx_q : idx_q;
				state_d = BK_DONE;
			end
			BK_DONE: begin
				out_valid = 1'b1;
				if (out_ready) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// result decided at the end of the walk
	always_ff @(posedge clk) begin
		if (state_q == BK_CHECK) begin
			res_q.ok <= 1'b0;
			res_q.full_res <= 1'b0;
			if (job_q.action != ACT_NOP) begin
				if (rd_match) begin
					res_q.ok <= (job_q.action != ACT_ADD);
				end else if (walk_end && job_q.action == ACT_ADD) begin
					if (have_tomb_q || !rd_used || rd_tomb) res_q.ok <= 1'b1;
					else res_q.full_res <= 1'b1;
				end
			end
		end
	end
	assign out_data = res_q;
endmodule

>>> hw/rtl/open_addressing_hash_set_top.sv
`timescale 1ns / 1ps
// path: the front takes one hash step per key byte (one for the empty key), the job
// passes through the queue, then the back reads and checks each probe and, for an add
// that inserts, writes the slot; flow: one transaction at a time per side, the slower
// side sets the rate; reset: a clearing pass over all TABLE_SIZE slots marks every slot
// free; the back starts nothing until it ends, while the front and queue may take up
// to 3 transactions
module open_addressing_hash_set_top import oahs_pkg::*; #(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF,
	parameter int KEY_CHARS = KEY_CHARS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data
);
	logic f_valid, f_ready, q_valid, q_ready;
	job_t f_job, q_job;

	oahs_front #(.KEY_CHARS(KEY_CHARS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);
	oahs_queue u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
	);
	oahs_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
		.clk, .arst_n, .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
		.out_valid, .out_ready, .out_data
	);

	a_full_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.ok && out_data.full_res))
		else $error("full flag with ok");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped");
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import oahs_pkg::*;

	localparam int NSLOT = TABLE_SIZE_DEF;
	localparam int MAXCH = KEY_CHARS_DEF;
	localparam int IDLE_LIMIT = 40000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	open_addressing_hash_set_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// shadow copy of the table
	logic [63:0] shadow_key [NSLOT];
	logic [3:0] shadow_len [NSLOT];
	bit shadow_used [NSLOT];
	bit shadow_tomb [NSLOT];

	out_item_t answer_q [$];
	int mismatches = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_full = 0;
	int n_ok = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int stall_cnt = 0;
	logic [63:0] key_pool [32];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] poly_hash(logic [63:0] key, int len);
		logic [31:0] h;
		h = 32'd0;
		for (int b = 0; b < len; b++)
			h = h * 32'd2047 + {24'd0, key[8*b +: 8]};
		return h;
	endfunction

	function automatic out_item_t apply_action(in_item_t it);
		out_item_t r;
		int len;
		logic [63:0] key;
		int idx;
		int tomb_idx;
		bit have_tomb;
		bit hit;
		int i;
		r = '0;
		len = (it.key_length > MAXCH) ? MAXCH : it.key_length;
		key = it.key_bytes;
		if (len < 8)
			key &= (64'd1 << (8 * len)) - 64'd1;
		idx = poly_hash(key, len) % NSLOT;
		have_tomb = 0;
		tomb_idx = 0;
		hit = 0;
		for (i = 0; shadow_used[idx] && i < NSLOT; i++) begin
			if (shadow_tomb[idx]) begin
				if (!have_tomb) begin
					have_tomb = 1;
					tomb_idx = idx;
				end
			end else if (shadow_len[idx] == len && shadow_key[idx] == key) begin
				hit = 1;
				break;
			end
			idx = (idx + i + 1) % NSLOT;
		end
		case (action_t'(it.action))
			ACT_ADD: begin
				if (!hit) begin
					if (have_tomb)
						idx = tomb_idx;
					if (!have_tomb && shadow_used[idx]) begin
						r.full_res = 1'b1;
					end else begin
						shadow_key[idx] = key;
						shadow_len[idx] = len[3:0];
						shadow_used[idx] = 1;
						shadow_tomb[idx] = 0;
						r.ok = 1'b1;
					end
				end
			end
			ACT_DEL: begin
				if (hit) begin
					shadow_tomb[idx] = 1;
					r.ok = 1'b1;
				end
			end
			ACT_QRY: r.ok = hit;
			default: r = '0;
		endcase
		return r;
	endfunction

	// one transaction on the input side, with bursty gaps
	task automatic send_item(in_item_t it);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		answer_q.push_back(apply_action(it));
		n_sent++;
	endtask

	task automatic send(action_t act, logic [63:0] key, logic [3:0] len);
		in_item_t it;
		it.action = act;
		it.key_bytes = key;
		it.key_length = len;
		send_item(it);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (answer_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_basic();
		send(ACT_QRY, 64'h0, 4'd1);
		send(ACT_ADD, 64'h41, 4'd1);
		send(ACT_ADD, 64'h41, 4'd1);
		send(ACT_QRY, 64'h41, 4'd1);
		send(ACT_DEL, 64'h41, 4'd1);
		send(ACT_QRY, 64'h41, 4'd1);
		send(ACT_DEL, 64'h41, 4'd1);
		send(ACT_ADD, 64'h41, 4'd1);
		// empty key and saturated lengths
		send(ACT_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
		send(ACT_QRY, 64'h0, 4'd0);
		send(ACT_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
		send(ACT_QRY, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
		send(ACT_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9);
		send(ACT_ADD, 64'h0, 4'd8);
		// bytes above the length are ignored
		send(ACT_QRY, 64'hDEAD_BEEF_0000_0041, 4'd1);
		send(ACT_ADD, 64'h0041, 4'd2);
		send(ACT_QRY, 64'h41, 4'd2);
		send(ACT_NOP, 64'h41, 4'd1);
		send(ACT_DEL, 64'h0, 4'd0);
		send(ACT_QRY, 64'h0, 4'd0);
		drain();
	endtask

	function automatic logic [63:0] rand_key();
		return {$urandom(), $urandom()};
	endfunction

	task automatic test_random(int count);
		logic [63:0] key;
		logic [3:0] len;
		int sel;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 85) begin
				key = key_pool[5'($urandom_range(0, 31))];
				len = 4'($urandom_range(1, 8));
			end else begin
				key = rand_key();
				len = 4'($urandom_range(0, 15));
			end
			sel = $urandom_range(0, 99);
			if (sel < 45) send(ACT_ADD, key, len);
			else if (sel < 70) send(ACT_DEL, key, len);
			else if (sel < 97) send(ACT_QRY, key, len);
			else send(ACT_NOP, key, len);
			if (n == count / 2)
				drain();
		end
		drain();
	endtask

	// fill every slot with distinct keys until adds report a full table
	task automatic test_fill();
		int seq;
		int fulls_before;
		seq = 0;
		fulls_before = n_full;
		while (n_full - fulls_before < 4 && seq < 2 * NSLOT) begin
			send(ACT_ADD, {32'hC0DE_0000, seq[31:0]}, 4'd8);
			seq++;
			while (answer_q.size() > 8) @(posedge clk);
			// n_full is counted on the output side
			if (seq > NSLOT + 32) drain();
		end
		send(ACT_QRY, {32'hC0DE_0000, 32'd5}, 4'd8);
		send(ACT_DEL, {32'hC0DE_0000, 32'd5}, 4'd8);
		send(ACT_ADD, 64'h1234_5678, 4'd4);
		send(ACT_ADD, rand_key(), 4'd8);
		drain();
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (answer_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: ok=%0b full=%0b",
						out_data.ok, out_data.full_res);
			end else begin
				out_item_t exp_r;
				exp_r = answer_q.pop_front();
				n_checked++;
				if (exp_r.full_res) n_full++;
				if (exp_r.ok) n_ok++;
				if (exp_r.ok !== out_data.ok || exp_r.full_res !== out_data.full_res) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d: exp ok=%0b full=%0b, got ok=%0b full=%0b",
							n_checked, exp_r.ok, exp_r.full_res,
							out_data.ok, out_data.full_res);
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver stall pattern, changing character in turn among four modes
	always @(negedge clk) begin
		stall_cnt <= stall_cnt + 1;
		case ((stall_cnt / 300) % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= (stall_cnt % 7) < 3;
			default: out_ready <= ($urandom_range(0, 1) != 0);
		endcase
	end

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		arst_n = 1'b0;
		for (int s = 0; s < NSLOT; s++) begin
			shadow_key[s] = '0;
			shadow_len[s] = '0;
			shadow_used[s] = 0;
			shadow_tomb[s] = 0;
		end
		for (int p = 0; p < 32; p++)
			key_pool[p] = rand_key();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic();
		test_random(400);
		test_fill();

		repeat (100) @(posedge clk);
		$display("sent %0d transactions, checked %0d results (%0d ok, %0d table-full)",
			n_sent, n_checked, n_ok, n_full);
		$display("covered add/delete/query/nop, tombstone reuse, odd lengths, full table");
		if (mismatches == 0 && answer_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("errors: %0d mismatches, %0d results missing",
				mismatches, answer_q.size());
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

>>> files.f
hw/rtl/oahs_pkg.sv
hw/rtl/oahs_front.sv
hw/rtl/oahs_queue.sv
hw/rtl/oahs_back.sv
hw/rtl/open_addressing_hash_set_top.sv
tb/tb.sv
